// File: rtl/pfb_pkg.sv
// shared types, constants and helper functions for the paged frame buffer draw engine
`timescale 1ns / 1ps

package pfb_pkg;

  localparam int unsigned SCREEN_WIDTH_DEF  = 128;
  localparam int unsigned SCREEN_HEIGHT_DEF = 32;

  // wide enough for corner sums and rotations without wrapping
  localparam int unsigned COORD_W = 19;

  localparam logic [7:0] FULL_MASK = 8'hFF;
  localparam logic [2:0] LAST_BIT  = 3'h7;

  typedef enum logic [1:0] {
    MODE_PIXEL,
    MODE_RECT,
    MODE_READ,
    MODE_NOP
  } mode_e;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_SET,
    OP_INVERT,
    OP_KEEP
  } draw_op_e;

  typedef enum logic [1:0] {
    ROT_0,
    ROT_90,
    ROT_180,
    ROT_270
  } rot_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ROT,
    ST_CLIP,
    ST_WALK,
    ST_READ,
    ST_READ_WAIT,
    ST_DONE
  } walk_state_e;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  typedef struct packed {
    mode_e              mode;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [14:0]        rect_width;
    logic [14:0]        rect_height;
    draw_op_e           draw_op;
  } item_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       clipped_away;
  } result_t;

  function automatic int unsigned col_bits(input int unsigned width);
    col_bits = $clog2(width);
  endfunction

  function automatic int unsigned page_bits(input int unsigned height);
    int unsigned pages;
    pages = (height + 7) / 8;
    page_bits = (pages > 1) ? $clog2(pages) : 1;
  endfunction

  function automatic logic [7:0] apply_op(input logic [7:0] data, input logic [7:0] mask,
                                          input draw_op_e op);
    logic [7:0] res;
    res = data;
    case (op)
      OP_CLEAR:  res = data & ~mask;
      OP_SET:    res = data | mask;
      OP_INVERT: res = data ^ mask;
      default:   res = data;
    endcase
    return res;
  endfunction

  function automatic point_t rotate_point(input point_t p, input rot_e rot,
                                          input coord_t w_last, input coord_t h_last);
    point_t r;
    r = p;
    case (rot)
      ROT_90: begin
        r.x = w_last - p.y;
        r.y = p.x;
      end
      ROT_180: begin
        r.x = w_last - p.x;
        r.y = h_last - p.y;
      end
      ROT_270: begin
        r.x = p.y;
        r.y = h_last - p.x;
      end
      default: r = p;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/pfb_frame_ram.sv
// frame store: one write port, one read port with registered read data
`timescale 1ns / 1ps

module pfb_frame_ram #(
  parameter int unsigned ADDR_W = 9
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [7:0]        wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [7:0]        rdata_o
);

  logic [7:0] mem [2**ADDR_W];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/pfb_walker.sv
// sequencer: clearing pass, corner rotation and clipping, read-modify-write walk, byte reads
`timescale 1ns / 1ps

module pfb_walker #(
  parameter int unsigned SCREEN_WIDTH  = pfb_pkg::SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT = pfb_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pfb_pkg::rot_e       rotation_i,
  input  logic                item_valid_i,
  input  pfb_pkg::item_t      item_i,
  output logic                ready_o,
  output logic                res_valid_o,
  input  logic                res_stall_i,
  output pfb_pkg::result_t    res_o,
  output logic                mem_we_o,
  output logic [pfb_pkg::page_bits(SCREEN_HEIGHT)+pfb_pkg::col_bits(SCREEN_WIDTH)-1:0]
                              mem_waddr_o,
  output logic [7:0]          mem_wdata_o,
  output logic [pfb_pkg::page_bits(SCREEN_HEIGHT)+pfb_pkg::col_bits(SCREEN_WIDTH)-1:0]
                              mem_raddr_o,
  input  logic [7:0]          mem_rdata_i
);

  import pfb_pkg::*;

  localparam int unsigned XW    = col_bits(SCREEN_WIDTH);
  localparam int unsigned PW    = page_bits(SCREEN_HEIGHT);
  localparam int unsigned YW    = PW + 3;
  localparam int unsigned AW    = PW + XW;
  localparam int unsigned PAGES = (SCREEN_HEIGHT + 7) / 8;

  localparam coord_t W_LAST    = coord_t'(SCREEN_WIDTH - 1);
  localparam coord_t H_LAST    = coord_t'(SCREEN_HEIGHT - 1);
  localparam coord_t PAGES_LIM = coord_t'(PAGES);

  walk_state_e      state_q, state_d;
  draw_op_e         op_q, op_d;
  point_t           p1_q, p1_d, p2_q, p2_d;
  logic [XW-1:0]    col_lo_q, col_lo_d, col_hi_q, col_hi_d, col_q, col_d;
  logic [YW-1:0]    row_lo_q, row_lo_d, row_hi_q, row_hi_d;
  logic [PW-1:0]    page_q, page_d;
  logic             issue_done_q, issue_done_d;
  logic             rd_vld_q, rd_vld_d;
  logic [AW-1:0]    rd_addr_q, rd_addr_d;
  logic [7:0]       rd_mask_q, rd_mask_d;
  logic [AW-1:0]    clr_addr_q, clr_addr_d;
  result_t          res_q, res_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_addr_q   <= '0;
      rd_vld_q     <= 1'b0;
      issue_done_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_addr_q   <= clr_addr_d;
      rd_vld_q     <= rd_vld_d;
      issue_done_q <= issue_done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    p1_q      <= p1_d;
    p2_q      <= p2_d;
    col_lo_q  <= col_lo_d;
    col_hi_q  <= col_hi_d;
    col_q     <= col_d;
    row_lo_q  <= row_lo_d;
    row_hi_q  <= row_hi_d;
    page_q    <= page_d;
    rd_addr_q <= rd_addr_d;
    rd_mask_q <= rd_mask_d;
    res_q     <= res_d;
  end

  always_comb begin
    coord_t        x1;
    coord_t        y1;
    coord_t        lx;
    coord_t        hx;
    coord_t        ly;
    coord_t        hy;
    coord_t        cl;
    coord_t        ch;
    coord_t        rl;
    coord_t        rh;
    logic [PW-1:0] page_lo;
    logic [PW-1:0] page_hi;
    logic [2:0]    lo_off;
    logic [2:0]    hi_off;
    logic [7:0]    page_mask;

    state_d      = state_q;
    op_d         = op_q;
    p1_d         = p1_q;
    p2_d         = p2_q;
    col_lo_d     = col_lo_q;
    col_hi_d     = col_hi_q;
    col_d        = col_q;
    row_lo_d     = row_lo_q;
    row_hi_d     = row_hi_q;
    page_d       = page_q;
    issue_done_d = issue_done_q;
    rd_vld_d     = 1'b0;
    rd_addr_d    = rd_addr_q;
    rd_mask_d    = rd_mask_q;
    clr_addr_d   = clr_addr_q;
    res_d        = res_q;

    ready_o     = 1'b0;
    res_valid_o = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = rd_addr_q;
    mem_wdata_o = apply_op(mem_rdata_i, rd_mask_q, op_q);
    mem_raddr_o = {page_q, col_q};

    x1 = coord_t'(item_i.pos_x);
    y1 = coord_t'(item_i.pos_y);

    lx = (p1_q.x < p2_q.x) ? p1_q.x : p2_q.x;
    hx = (p1_q.x < p2_q.x) ? p2_q.x : p1_q.x;
    ly = (p1_q.y < p2_q.y) ? p1_q.y : p2_q.y;
    hy = (p1_q.y < p2_q.y) ? p2_q.y : p1_q.y;
    cl = (lx < 0) ? '0 : lx;
    ch = (hx > W_LAST) ? W_LAST : hx;
    rl = (ly < 0) ? '0 : ly;
    rh = (hy > H_LAST) ? H_LAST : hy;

    page_lo   = row_lo_q[YW-1:3];
    page_hi   = row_hi_q[YW-1:3];
    lo_off    = (page_q == page_lo) ? row_lo_q[2:0] : 3'd0;
    hi_off    = (page_q == page_hi) ? row_hi_q[2:0] : LAST_BIT;
    page_mask = (FULL_MASK >> (LAST_BIT - hi_off)) & (FULL_MASK << lo_off);

    unique case (state_q)
      ST_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = clr_addr_q;
        mem_wdata_o = '0;
        clr_addr_d  = clr_addr_q + AW'(1);
        if (clr_addr_q == {AW{1'b1}}) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        ready_o = 1'b1;
        if (item_valid_i) begin
          op_d   = item_i.draw_op;
          p1_d   = '{x: x1, y: y1};
          if (item_i.mode == MODE_RECT) begin
            p2_d.x = x1 + coord_t'({1'b0, item_i.rect_width}) - coord_t'(1);
            p2_d.y = y1 + coord_t'({1'b0, item_i.rect_height}) - coord_t'(1);
          end else begin
            p2_d = '{x: x1, y: y1};
          end
          res_d = '0;
          unique case (item_i.mode)
            MODE_PIXEL: state_d = ST_ROT;
            MODE_RECT: begin
              if (item_i.rect_width == '0 || item_i.rect_height == '0) begin
                res_d.clipped_away = 1'b1;
                state_d            = ST_DONE;
              end else begin
                state_d = ST_ROT;
              end
            end
            MODE_READ: state_d = ST_READ;
            default:   state_d = ST_DONE;
          endcase
        end
      end

      ST_ROT: begin
        p1_d    = rotate_point(p1_q, rotation_i, W_LAST, H_LAST);
        p2_d    = rotate_point(p2_q, rotation_i, W_LAST, H_LAST);
        state_d = ST_CLIP;
      end

      ST_CLIP: begin
        res_d = '0;
        if (lx > W_LAST || hx < 0 || ly > H_LAST || hy < 0) begin
          res_d.clipped_away = 1'b1;
          state_d            = ST_DONE;
        end else begin
          col_lo_d     = cl[XW-1:0];
          col_hi_d     = ch[XW-1:0];
          col_d        = cl[XW-1:0];
          row_lo_d     = rl[YW-1:0];
          row_hi_d     = rh[YW-1:0];
          page_d       = rl[YW-1:3];
          issue_done_d = 1'b0;
          state_d      = (op_q == OP_KEEP) ? ST_DONE : ST_WALK;
        end
      end

      ST_WALK: begin
        // read the next byte while the previous one is written back
        if (!issue_done_q) begin
          rd_vld_d  = 1'b1;
          rd_addr_d = {page_q, col_q};
          rd_mask_d = page_mask;
          if (col_q == col_hi_q) begin
            col_d = col_lo_q;
            if (page_q == page_hi) begin
              issue_done_d = 1'b1;
            end else begin
              page_d = page_q + PW'(1);
            end
          end else begin
            col_d = col_q + XW'(1);
          end
        end
        mem_we_o = rd_vld_q;
        if (issue_done_q && !rd_vld_q) begin
          state_d = ST_DONE;
        end
      end

      ST_READ: begin
        mem_raddr_o = {p1_q.y[PW-1:0], p1_q.x[XW-1:0]};
        rd_vld_d    = (p1_q.x >= 0) && (p1_q.x <= W_LAST) &&
                      (p1_q.y >= 0) && (p1_q.y < PAGES_LIM);
        state_d     = ST_READ_WAIT;
      end

      ST_READ_WAIT: begin
        res_d.read_byte    = rd_vld_q ? mem_rdata_i : 8'h00;
        res_d.clipped_away = 1'b0;
        state_d            = ST_DONE;
      end

      ST_DONE: begin
        res_valid_o = 1'b1;
        if (!res_stall_i) begin
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  assign res_o = res_q;

endmodule

// File: rtl/paged_framebuffer_draw_engine.sv
// top level: paged monochrome frame buffer with pixel, rectangle fill and byte read items
// items: the sequencer handles one at a time; a full default screen fill touches 512 bytes;
// the result register lets the next item in while the last result waits to be taken
// reset: clearing pass writes all 2^(page bits + column bits) bytes (512 by default), no items until done
`timescale 1ns / 1ps

module paged_framebuffer_draw_engine #(
  parameter int unsigned SCREEN_WIDTH  = pfb_pkg::SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT = pfb_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // rotation register write
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_wdata_i,
  // input items
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         mode_i,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  input  logic [14:0]        rect_width_i,
  input  logic [14:0]        rect_height_i,
  input  logic [1:0]         draw_op_i,
  // result items
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         read_byte_o,
  output logic               clipped_away_o
);

  import pfb_pkg::*;

  localparam int unsigned AW = page_bits(SCREEN_HEIGHT) + col_bits(SCREEN_WIDTH);

  rot_e          rotation_q, rotation_d;
  item_t         item;
  logic          walker_ready;
  logic          res_valid;
  logic          res_stall;
  result_t       res;
  logic          out_valid_q, out_valid_d;
  result_t       out_res_q, out_res_d;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;

  // rotation register, to be written only between items; the block itself does not enforce this
  assign rotation_d = cfg_we_i ? rot_e'(cfg_wdata_i) : rotation_q;

  // gather the item fields for the sequencer
  assign item = '{
    mode:        mode_e'(mode_i),
    pos_x:       pos_x_i,
    pos_y:       pos_y_i,
    rect_width:  rect_width_i,
    rect_height: rect_height_i,
    draw_op:     draw_op_e'(draw_op_i)
  };

  // the sequencer takes an item only when idle (also blocks during the clearing pass)
  assign in_stall_o = !walker_ready;

  // result register: the sequencer hands over whenever the register is free or being drained
  assign res_stall = out_valid_q && out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    if (res_valid && !res_stall) begin
      out_valid_d = 1'b1;
      out_res_d   = res;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rotation_q  <= ROT_0;
      out_valid_q <= 1'b0;
    end else begin
      rotation_q  <= rotation_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q <= out_res_d;
  end

  assign out_valid_o    = out_valid_q;
  assign read_byte_o    = out_res_q.read_byte;
  assign clipped_away_o = out_res_q.clipped_away;

  pfb_walker #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_walker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rotation_i   (rotation_q),
    .item_valid_i (in_valid_i),
    .item_i       (item),
    .ready_o      (walker_ready),
    .res_valid_o  (res_valid),
    .res_stall_i  (res_stall),
    .res_o        (res),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata)
  );

  pfb_frame_ram #(
    .ADDR_W (AW)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

// File: bench/tb.sv
// self-checking bench for the paged frame buffer draw engine: shadow frame store, random items
`timescale 1ns / 1ps

module tb;
  import pfb_pkg::*;

  // geometry of the default build
  localparam int SCR_W       = SCREEN_WIDTH_DEF;
  localparam int SCR_H       = SCREEN_HEIGHT_DEF;
  localparam int PAGES       = (SCR_H + 7) / 8;
  localparam int STORE_DEPTH = PAGES * SCR_W;

  // cycles with no item moving on either side before the run is called hung;
  // covers the clearing pass, a full screen fill and the longest gap and stall
  localparam int QUIET_LIMIT = 4000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 141;
  localparam int REPORT_MAX  = 10;

  // shadow copy of the frame store and the queue of outcomes still owed
  class fb_shadow;
    logic [7:0]  shadow_store [STORE_DEPTH];
    rot_e        turn_sel;
    result_t     queued_outcomes [$];
    int unsigned bad_count;

    function new();
      foreach (shadow_store[i]) shadow_store[i] = 8'h00;
      turn_sel  = ROT_0;
      bad_count = 0;
    endfunction

    function void set_turn(rot_e r);
      turn_sel = r;
    endfunction

    function int unsigned outstanding();
      return queued_outcomes.size();
    endfunction

    function void turn_point(inout int x, inout int y);
      int ox, oy;
      ox = x;
      oy = y;
      case (turn_sel)
        ROT_90: begin
          x = SCR_W - 1 - oy;
          y = ox;
        end
        ROT_180: begin
          x = SCR_W - 1 - ox;
          y = SCR_H - 1 - oy;
        end
        ROT_270: begin
          x = oy;
          y = SCR_H - 1 - ox;
        end
        default: ;
      endcase
    endfunction

    function void modify_byte(int col, int page, logic [7:0] m, draw_op_e op);
      int idx;
      idx = page * SCR_W + col;
      if (idx < 0 || idx >= STORE_DEPTH) return;
      case (op)
        OP_CLEAR:  shadow_store[idx] = shadow_store[idx] & ~m;
        OP_SET:    shadow_store[idx] = shadow_store[idx] | m;
        OP_INVERT: shadow_store[idx] = shadow_store[idx] ^ m;
        default:   ;
      endcase
    endfunction

    // apply one accepted item to the shadow store and queue what it yields
    function void take_item(item_t it);
      int x1, y1, x2, y2, w, h, t, p, c, base, lo, hi;
      logic [7:0] m;
      result_t r;
      r  = '0;
      x1 = int'($signed(it.pos_x));
      y1 = int'($signed(it.pos_y));
      w  = int'(it.rect_width);
      h  = int'(it.rect_height);
      case (it.mode)
        MODE_PIXEL: begin
          turn_point(x1, y1);
          if (x1 < 0 || x1 >= SCR_W || y1 < 0 || y1 >= SCR_H) begin
            r.clipped_away = 1'b1;
          end else begin
            m = 8'h01 << (y1 & 7);
            modify_byte(x1, y1 >>> 3, m, it.draw_op);
          end
        end
        MODE_RECT: begin
          if (w == 0 || h == 0) begin
            r.clipped_away = 1'b1;
          end else begin
            x2 = x1 + w - 1;
            y2 = y1 + h - 1;
            turn_point(x1, y1);
            turn_point(x2, y2);
            if (x1 > x2) begin
              t = x1; x1 = x2; x2 = t;
            end
            if (y1 > y2) begin
              t = y1; y1 = y2; y2 = t;
            end
            if (x1 > SCR_W - 1 || x2 < 0 || y1 > SCR_H - 1 || y2 < 0) begin
              r.clipped_away = 1'b1;
            end else begin
              if (x1 < 0) x1 = 0;
              if (x2 > SCR_W - 1) x2 = SCR_W - 1;
              if (y1 < 0) y1 = 0;
              if (y2 > SCR_H - 1) y2 = SCR_H - 1;
              for (p = y1 >>> 3; p <= (y2 >>> 3); p++) begin
                base = p * 8;
                lo   = (y1 > base) ? y1 : base;
                hi   = (y2 < base + 7) ? y2 : base + 7;
                m    = (8'hFF >> (7 - (hi - base))) & (8'hFF << (lo - base));
                for (c = x1; c <= x2; c++) modify_byte(c, p, m, it.draw_op);
              end
            end
          end
        end
        MODE_READ: begin
          if (x1 >= 0 && x1 < SCR_W && y1 >= 0 && y1 < PAGES)
            r.read_byte = shadow_store[y1 * SCR_W + x1];
        end
        default: ;
      endcase
      queued_outcomes.push_back(r);
    endfunction

    function void note_bad(string msg);
      bad_count++;
      if (bad_count <= REPORT_MAX) $display("mismatch at %0t: %s", $realtime, msg);
    endfunction

    // compare one accepted result with the oldest owed outcome
    function void match_outcome(logic [7:0] rb, logic clip);
      result_t want;
      if (queued_outcomes.size() == 0) begin
        note_bad($sformatf("result with nothing owed: read_byte %02h clipped_away %0b",
                           rb, clip));
        return;
      end
      want = queued_outcomes.pop_front();
      if (rb !== want.read_byte)
        note_bad($sformatf("read_byte expected %02h actual %02h", want.read_byte, rb));
      if (clip !== want.clipped_away)
        note_bad($sformatf("clipped_away expected %0b actual %0b", want.clipped_away, clip));
    endfunction
  endclass

  // clock, reset and block inputs, all known from time zero
  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               cfg_we_i      = 1'b0;
  logic [1:0]         cfg_wdata_i   = 2'd0;
  logic               in_valid_i    = 1'b0;
  logic               in_stall_o;
  logic [1:0]         mode_i        = 2'd0;
  logic signed [15:0] pos_x_i       = '0;
  logic signed [15:0] pos_y_i       = '0;
  logic [14:0]        rect_width_i  = '0;
  logic [14:0]        rect_height_i = '0;
  logic [1:0]         draw_op_i     = 2'd0;
  logic               out_valid_o;
  logic               out_stall_i   = 1'b0;
  logic [7:0]         read_byte_o;
  logic               clipped_away_o;

  fb_shadow    sb = new();
  int unsigned quiet_cycles = 0;
  bit          burst_send = 1'b0;
  bit          burst_take = 1'b0;
  item_t       opening_items [$];
  rot_e        turn_plan [4] = '{ROT_270, ROT_90, ROT_0, ROT_180};

  paged_framebuffer_draw_engine uut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // hang detection: count cycles in which neither side moves an item
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("tb failed");
    $finish;
  end

  function automatic item_t mk_item(mode_e m, int x, int y, int w, int h, draw_op_e op);
    item_t it;
    it.mode        = m;
    it.pos_x       = 16'(x);
    it.pos_y       = 16'(y);
    it.rect_width  = 15'(w);
    it.rect_height = 15'(h);
    it.draw_op     = op;
    return it;
  endfunction

  function automatic int pick(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  // random item; coordinates mostly land near the screen as seen after the turn
  function automatic item_t rand_item(rot_e rot);
    item_t it;
    int sel, sz, xr, yr;
    bit tall;
    tall = (rot == ROT_90 || rot == ROT_270);
    xr   = tall ? SCR_H : SCR_W;
    yr   = tall ? SCR_W : SCR_H;
    sel  = $urandom_range(0, 99);
    // fields the mode ignores still get random content
    it.draw_op     = draw_op_e'($urandom_range(0, 3));
    it.pos_x       = 16'($urandom);
    it.pos_y       = 16'($urandom);
    it.rect_width  = 15'($urandom);
    it.rect_height = 15'($urandom);
    if (sel < 36) begin
      it.mode = MODE_PIXEL;
      if ($urandom_range(0, 9) != 0) begin
        it.pos_x = 16'(pick(-4, xr + 3));
        it.pos_y = 16'(pick(-4, yr + 3));
      end
    end else if (sel < 70) begin
      it.mode = MODE_RECT;
      if ($urandom_range(0, 9) != 0) begin
        it.pos_x = 16'(pick(-20, xr + 10));
        it.pos_y = 16'(pick(-20, yr + 10));
      end
      // keep most fills small, a few reach huge sizes
      sz = $urandom_range(0, 99);
      if (sz < 80) begin
        it.rect_width  = 15'(pick(0, 24));
        it.rect_height = 15'(pick(0, 24));
      end else if (sz < 95) begin
        it.rect_width  = 15'(pick(0, 160));
        it.rect_height = 15'(pick(0, 160));
      end
    end else if (sel < 96) begin
      it.mode = MODE_READ;
      sz = $urandom_range(0, 9);
      if (sz < 7) begin
        it.pos_x = 16'(pick(0, SCR_W - 1));
        it.pos_y = 16'(pick(0, PAGES - 1));
      end else if (sz < 9) begin
        it.pos_x = 16'(pick(-1, SCR_W));
        it.pos_y = 16'(pick(-1, PAGES));
      end
    end else begin
      it.mode = MODE_NOP;
    end
    return it;
  endfunction

  // offer one item after a random gap and hold it until accepted
  task automatic send_item(input item_t it);
    int gap;
    gap = burst_send ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    mode_i        <= it.mode;
    pos_x_i       <= it.pos_x;
    pos_y_i       <= it.pos_y;
    rect_width_i  <= it.rect_width;
    rect_height_i <= it.rect_height;
    draw_op_i     <= it.draw_op;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
    sb.take_item(it);
  endtask

  // stop offering and let every owed result come out
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
  endtask

  // rotation register write, only ever issued with no item in flight
  task automatic write_rotation(input rot_e r);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= r;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_turn(r);
  endtask

  // result side: random stall per item, with stretches of none
  initial begin : result_sink
    int hold;
    forever begin
      if ($urandom_range(0, 99) < 4) burst_take = !burst_take;
      hold = burst_take ? 0 : $urandom_range(0, 18);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
      sb.match_outcome(read_byte_o, clipped_away_o);
    end
  end

  initial begin : stimulus
    rot_e rot;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    // register written straight after reset, during the clearing pass, before any item
    write_rotation(ROT_0);

    // corner pixels and read-back of both ends of the store
    opening_items.push_back(mk_item(MODE_PIXEL, 0, 0, 0, 0, OP_SET));
    opening_items.push_back(mk_item(MODE_PIXEL, SCR_W - 1, SCR_H - 1, 0, 0, OP_SET));
    opening_items.push_back(mk_item(MODE_READ, 0, 0, 0, 0, OP_KEEP));
    opening_items.push_back(mk_item(MODE_READ, SCR_W - 1, PAGES - 1, 0, 0, OP_KEEP));
    // pixels just and far off screen, extreme coordinates
    opening_items.push_back(mk_item(MODE_PIXEL, -1, 0, 0, 0, OP_SET));
    opening_items.push_back(mk_item(MODE_PIXEL, SCR_W, SCR_H - 1, 0, 0, OP_SET));
    opening_items.push_back(mk_item(MODE_PIXEL, -32768, 32767, 32767, 32767, OP_INVERT));
    opening_items.push_back(mk_item(MODE_PIXEL, 32767, -32768, 0, 0, OP_SET));
    // invert and keep on one pixel with a read-back, then clear on the first corner
    opening_items.push_back(mk_item(MODE_PIXEL, 5, 9, 0, 0, OP_INVERT));
    opening_items.push_back(mk_item(MODE_PIXEL, 5, 9, 0, 0, OP_KEEP));
    opening_items.push_back(mk_item(MODE_READ, 5, 1, 0, 0, OP_KEEP));
    opening_items.push_back(mk_item(MODE_PIXEL, 0, 0, 0, 0, OP_CLEAR));
    // zero width and zero height fills draw nothing
    opening_items.push_back(mk_item(MODE_RECT, 10, 10, 0, 5, OP_SET));
    opening_items.push_back(mk_item(MODE_RECT, 10, 10, 5, 0, OP_SET));
    // partial top and bottom masks across a page border
    opening_items.push_back(mk_item(MODE_RECT, 3, 5, 10, 7, OP_SET));
    opening_items.push_back(mk_item(MODE_READ, 3, 0, 0, 0, OP_KEEP));
    opening_items.push_back(mk_item(MODE_READ, 12, 1, 0, 0, OP_KEEP));
    // whole screen, then huge fills, one with a corner sum that would wrap in 16 bits
    opening_items.push_back(mk_item(MODE_RECT, 0, 0, SCR_W, SCR_H, OP_INVERT));
    opening_items.push_back(mk_item(MODE_RECT, 32767, 0, 32767, 5, OP_SET));
    opening_items.push_back(mk_item(MODE_RECT, -32768, -32768, 32767, 32767, OP_SET));
    opening_items.push_back(mk_item(MODE_RECT, -100, -100, 32767, 32767, OP_CLEAR));
    // keep on an off-screen and an on-screen fill
    opening_items.push_back(mk_item(MODE_RECT, 200, 0, 5, 5, OP_KEEP));
    opening_items.push_back(mk_item(MODE_RECT, 100, 20, 10, 10, OP_KEEP));
    // reads outside the store, the unused mode
    opening_items.push_back(mk_item(MODE_READ, -1, 0, 0, 0, OP_KEEP));
    opening_items.push_back(mk_item(MODE_READ, SCR_W, 0, 0, 0, OP_KEEP));
    opening_items.push_back(mk_item(MODE_READ, 0, PAGES, 0, 0, OP_KEEP));
    opening_items.push_back(mk_item(MODE_READ, 0, -1, 0, 0, OP_KEEP));
    opening_items.push_back(mk_item(MODE_NOP, 0, 0, 1, 1, OP_SET));
    foreach (opening_items[i]) send_item(opening_items[i]);

    // random phases, each under its own rotation; all four turns come first
    for (int ph = 0; ph < PHASES; ph++) begin
      drain_results();
      rot = (ph < 4) ? turn_plan[ph] : rot_e'($urandom_range(0, 3));
      write_rotation(rot);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 99) < 4) burst_send = !burst_send;
        // now and then hold off until the engine has emptied
        if ($urandom_range(0, 199) == 0) drain_results();
        send_item(rand_item(rot));
      end
    end

    drain_results();
    // a few more cycles to catch any stray result
    repeat (20) @(posedge clk_i);
    if (sb.bad_count == 0 && sb.outstanding() == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

endmodule

// File: sim.f
rtl/pfb_pkg.sv
rtl/pfb_frame_ram.sv
rtl/pfb_walker.sv
rtl/paged_framebuffer_draw_engine.sv
bench/tb.sv
